/* hdl/tdpc_pkg.sv */
// package for the trial-division prime counter
// shared constants and control structs; no dependencies

package tdpc_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int FIRST_DIVISOR  = 2;

  // status from the remainder unit to the sequencer
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

  // finished result from the sequencer to the output stage
  typedef struct packed {
    logic valid;
    logic prime;
    logic last;
  } seq_res_t;

endpackage

/* hdl/tdpc_if.sv */
// valid/ready channel interfaces for the prime counter
// depends on tdpc_pkg for default widths

interface tdpc_in_if #(
  parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface tdpc_out_if #(
  parameter int COUNT_BITS = tdpc_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  value_is_prime;
  logic [COUNT_BITS-1:0] prime_count;
  logic                  last_item_res;

  modport source (output valid, output value_is_prime, output prime_count,
                  output last_item_res, input ready);
  modport sink   (input valid, input value_is_prime, input prime_count,
                  input last_item_res, output ready);
endinterface

/* hdl/tdpc_rem_unit.sv */
// shared remainder unit: restoring division, one quotient bit per cycle
// depends on tdpc_pkg

module tdpc_rem_unit #(
  parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF,
  parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [VALUE_BITS-1:0]    dividend,
  input  logic [DIV_BITS-1:0]      divisor,
  output tdpc_pkg::rem_stat_t      stat
);
  import tdpc_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] sh_r, sh_nxt;
  logic [DIV_BITS-1:0]   rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   dvs_r, dvs_nxt;
  logic [DIV_BITS:0]     trial;

  assign trial = {rem_r, sh_r[VALUE_BITS-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(VALUE_BITS);
      sh_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_BITS'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DIV_BITS-1:0];
      end
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

/* hdl/tdpc_seq.sv */
// divisor sequencer: steps trial divisors and tracks the divisor square
// depends on tdpc_pkg; drives tdpc_rem_unit

module tdpc_seq #(
  parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF,
  parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [VALUE_BITS-1:0]    value,
  input  logic                     last,
  output logic                     ready,
  output logic                     rem_start,
  output logic [VALUE_BITS-1:0]    rem_dividend,
  output logic [DIV_BITS-1:0]      rem_divisor,
  input  tdpc_pkg::rem_stat_t      rem_stat,
  output tdpc_pkg::seq_res_t       res,
  input  logic                     res_take
);
  import tdpc_pkg::*;

  localparam int SQ_BITS = VALUE_BITS + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  last_r, last_nxt;
  logic                  prime_r, prime_nxt;
  logic [DIV_BITS-1:0]   d_r, d_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  start_r, start_nxt;

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    prime_nxt = prime_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    start_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt  = value;
          last_nxt = last;
          d_nxt    = DIV_BITS'(FIRST_DIVISOR);
          sq_nxt   = SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
          if (value < VALUE_BITS'(FIRST_DIVISOR)) begin
            prime_nxt = 1'b0;
            state_nxt = S_HOLD;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sq_r > SQ_BITS'(val_r)) begin
          prime_nxt = 1'b1;
          state_nxt = S_HOLD;
        end else begin
          start_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_HOLD;
          end else begin
            d_nxt     = d_r + DIV_BITS'(1);
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SQ_BITS'({d_r, 1'b1});
            state_nxt = S_CHECK;
          end
        end
      end
      S_HOLD: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
    val_r   <= val_nxt;
    last_r  <= last_nxt;
    prime_r <= prime_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
  end

  assign ready        = (state_r == S_IDLE);
  assign rem_start    = start_r;
  assign rem_dividend = val_r;
  assign rem_divisor  = d_r;
  assign res.valid    = (state_r == S_HOLD);
  assign res.prime    = prime_r;
  assign res.last     = last_r;

endmodule

/* hdl/trial_division_prime_counter.sv */
// Trial-division prime counter. Each input item is one unsigned value with a
// last-of-set marker; each gives one result item: a prime flag, the count of
// primes in the set so far (including this value, saturating at all ones)
// and a copy of the marker. The count clears after the last item of a set.
// One item is worked at a time and the input is not ready meanwhile. Values
// below 2 go straight to the result; otherwise each trial divisor, from 2 up
// to the smallest factor or up to floor(sqrt(value)), is tried in the shared
// one-bit-per-cycle remainder unit, followed by the final bound check and
// the hand-off to the output register. A finished result waits in an output
// register while the next item is accepted; a second finished result waits
// in the sequencer, with the input held off, until that register empties.
// Depends on tdpc_pkg, tdpc_if, tdpc_seq and tdpc_rem_unit.

module trial_division_prime_counter #(
  parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = tdpc_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tdpc_in_if.sink     in_ch,
  tdpc_out_if.source  out_ch
);
  import tdpc_pkg::*;

  localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

  logic                  seq_ready;
  logic                  rem_start;
  logic [VALUE_BITS-1:0] rem_dividend;
  logic [DIV_BITS-1:0]   rem_divisor;
  rem_stat_t             rem_stat;
  seq_res_t              res;
  logic                  res_take;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_prime_r, out_prime_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] cnt_inc;

  tdpc_seq #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DIV_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_ch.valid && seq_ready),
    .value        (in_ch.value),
    .last         (in_ch.last_item),
    .ready        (seq_ready),
    .rem_start    (rem_start),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .rem_stat     (rem_stat),
    .res          (res),
    .res_take     (res_take)
  );

  tdpc_rem_unit #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DIV_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .stat     (rem_stat)
  );

  assign in_ch.ready = seq_ready;
  assign res_take    = res.valid && (!out_valid_r || out_ch.ready);

  // saturating increment
  assign cnt_inc = (res.prime && (cnt_r != '1)) ? cnt_r + COUNT_BITS'(1) : cnt_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    cnt_nxt       = cnt_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_prime_nxt = res.prime;
      out_count_nxt = cnt_inc;
      out_last_nxt  = res.last;
      cnt_nxt       = res.last ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    out_prime_r <= out_prime_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.value_is_prime = out_prime_r;
  assign out_ch.prime_count    = out_count_r;
  assign out_ch.last_item_res  = out_last_r;

endmodule

/* hdl/tdpc_checker.sv */
// port-level checks for the prime counter, bound to the top level
// depends on trial_division_prime_counter and tdpc_if

module tdpc_checker #(
  parameter int COUNT_BITS = tdpc_pkg::COUNT_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_value_is_prime,
  input logic [COUNT_BITS-1:0] out_prime_count,
  input logic                  out_last_item_res
);

  // one item in flight: the input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after an item was accepted");

  // a prime result always carries a nonzero count
  a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_is_prime |-> out_prime_count != '0)
    else $error("prime result with zero count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value_is_prime) &&
      $stable(out_prime_count) && $stable(out_last_item_res))
    else $error("result changed while stalled");

endmodule

bind trial_division_prime_counter tdpc_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_tdpc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_value_is_prime (out_ch.value_is_prime),
  .out_prime_count    (out_ch.prime_count),
  .out_last_item_res  (out_ch.last_item_res)
);

/* sim/trial_division_prime_counter_tb.sv */
// testbench for trial_division_prime_counter: directed table, a long receiver hold-off,
// then random sets under sender gaps and receiver stalls, checked by a local predictor
// depends on tdpc_pkg, tdpc_if and the trial_division_prime_counter rtl
`timescale 1ns / 1ps

module trial_division_prime_counter_tb;

  localparam int VALUE_W     = tdpc_pkg::VALUE_BITS_DEF;
  localparam int COUNT_W     = tdpc_pkg::COUNT_BITS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 410;
  localparam int N_DIRECTED  = 18;
  localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

  typedef struct packed {
    logic               prime;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               typed;
    logic               prime;
    logic [COUNT_W-1:0] count;
  } dir_row_t;

  // typed rows carry a hand-written expectation
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{16'd0,     1'b0, 1'b1, 1'b0, 16'd0},
    '{16'd1,     1'b0, 1'b1, 1'b0, 16'd0},
    '{16'd2,     1'b0, 1'b1, 1'b1, 16'd1},
    '{16'd3,     1'b0, 1'b1, 1'b1, 16'd2},
    '{16'd4,     1'b0, 1'b1, 1'b0, 16'd2},
    '{16'hffff,  1'b0, 1'b1, 1'b0, 16'd2},
    '{16'd65521, 1'b1, 1'b1, 1'b1, 16'd3},
    '{16'd65521, 1'b0, 1'b1, 1'b1, 16'd1},
    '{16'd0,     1'b1, 1'b1, 1'b0, 16'd1},
    '{16'd2,     1'b1, 1'b1, 1'b1, 16'd1},
    '{16'd1,     1'b1, 1'b1, 1'b0, 16'd0},
    '{16'd63001, 1'b0, 1'b0, 1'b0, 16'd0},
    '{16'h8000,  1'b0, 1'b0, 1'b0, 16'd0},
    '{16'd32749, 1'b0, 1'b0, 1'b0, 16'd0},
    '{16'd25,    1'b0, 1'b0, 1'b0, 16'd0},
    '{16'd65534, 1'b0, 1'b0, 1'b0, 16'd0},
    '{16'd49,    1'b0, 1'b0, 1'b0, 16'd0},
    '{16'd65519, 1'b1, 1'b0, 1'b0, 16'd0}
  };

  logic clk;
  logic rst_n;

  tdpc_in_if  #(.VALUE_BITS(VALUE_W)) in_if ();
  tdpc_out_if #(.COUNT_BITS(COUNT_W)) out_if ();

  trial_division_prime_counter #(
    .VALUE_BITS(VALUE_W),
    .COUNT_BITS(COUNT_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  result_t            pending_results[$];
  logic [COUNT_W-1:0] set_prime_tally;
  int                 mismatch_count;
  int                 results_checked;
  int                 primes_reported;
  int                 sets_closed;
  int                 items_sent;
  int                 sender_idle_pct;
  int                 receiver_stall_pct;
  bit                 hold_off_req;
  int                 idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_prime_value(logic [VALUE_W-1:0] v);
    longint unsigned n;
    longint unsigned d;
    n = v;
    if (n < tdpc_pkg::FIRST_DIVISOR) return 1'b0;
    for (d = tdpc_pkg::FIRST_DIVISOR; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advances the per-set tally and returns the result this item should give
  function automatic result_t predict_result(logic [VALUE_W-1:0] v, logic l);
    result_t r;
    r.prime = is_prime_value(v);
    r.count = set_prime_tally;
    if (r.prime && r.count != COUNT_TOP) r.count = r.count + 1'b1;
    r.last = l;
    set_prime_tally = l ? '0 : r.count;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(logic [VALUE_W-1:0] v, logic l, logic typed, result_t typed_res);
    result_t r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.value     <= v;
    in_if.last_item <= l;
    do @(posedge clk); while (!in_if.ready);
    r = predict_result(v, l);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pick_random(output logic [VALUE_W-1:0] v, output logic l);
    int sel;
    logic [VALUE_W-1:0] specials [8];
    specials = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65521, 16'hffff, 16'd63001, 16'd65534};
    sel = $urandom_range(0, 99);
    if (sel < 60)      v = VALUE_W'($urandom_range(0, 255));
    else if (sel < 85) v = VALUE_W'($urandom_range(256, 4095));
    else if (sel < 95) v = VALUE_W'($urandom);
    else               v = specials[$urandom_range(0, 7)];
    l = ($urandom_range(0, 7) == 0);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      if (out_if.value_is_prime) primes_reported++;
      if (out_if.last_item_res) sets_closed++;
      if (pending_results.size() == 0) begin
        report_mismatch("result item arrived with none outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_if.value_is_prime !== want.prime)
          report_mismatch($sformatf("value_is_prime got %b want %b",
                                    out_if.value_is_prime, want.prime));
        if (out_if.prime_count !== want.count)
          report_mismatch($sformatf("prime_count got %0d want %0d",
                                    out_if.prime_count, want.count));
        if (out_if.last_item_res !== want.last)
          report_mismatch($sformatf("last_item_res got %b want %b",
                                    out_if.last_item_res, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] v;
    logic               l;
    result_t            typed_res;
    int                 phase;
    int                 idle_tab  [4];
    int                 stall_tab [4];
    idle_tab  = '{0, 54, 0, 37};
    stall_tab = '{0, 0, 54, 37};
    rst_n              = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.value        <= '0;
    in_if.last_item    <= 1'b0;
    set_prime_tally    = '0;
    mismatch_count     = 0;
    results_checked    = 0;
    primes_reported    = 0;
    sets_closed        = 0;
    items_sent         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_req       = 1'b0;
    idle_cycles        = 0;
    typed_res          = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      typed_res.prime = directed_rows[i].prime;
      typed_res.count = directed_rows[i].count;
      typed_res.last  = directed_rows[i].last;
      send_item(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                typed_res);
    end
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_item(VALUE_W'($urandom_range(0, 63)), ($urandom_range(0, 3) == 0), 1'b0, typed_res);
    end
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = idle_tab[phase];
      receiver_stall_pct = stall_tab[phase];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick_random(v, l);
        send_item(v, l, 1'b0, typed_res);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("run covered %0d items and %0d results in %0d sets, %0d reported prime",
             items_sent, results_checked, sets_closed, primes_reported);
    $display("one long receiver hold-off; idle mixes of sender and receiver: 4");
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
